@@ rtl/ehp_pkg.sv @@
// ----------------------------------------------------------------------------
// ehp_pkg
// types, constants and helpers for the ethernet / ipv4 header parser
// ----------------------------------------------------------------------------
package ehp_pkg;

	localparam int unsigned MacW      = 48;
	localparam int unsigned PosW      = 7;
	localparam logic [6:0]  EthHdrBytes = 7'd14;
	localparam logic [6:0]  EthTypeLast = 7'd13;
	localparam logic [6:0]  SrcStart    = 7'd6;
	localparam logic [6:0]  TypeStart   = 7'd12;
	localparam logic [5:0]  IpMinBytes  = 6'd12;
	localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
	localparam logic [7:0]  ProtoIcmp = 8'h01;
	localparam logic [7:0]  ProtoTcp  = 8'h06;
	localparam logic [7:0]  ProtoUdp  = 8'h11;
	localparam logic [7:0]  IhlMask   = 8'h0F;
	localparam logic [15:0] SumPass   = 16'hFFFF;

	// ipv4 header byte offsets
	localparam logic [6:0] IpVerIhl  = 7'd0;
	localparam logic [6:0] IpLenHi   = 7'd2;
	localparam logic [6:0] IpLenLo   = 7'd3;
	localparam logic [6:0] IpTtl     = 7'd8;
	localparam logic [6:0] IpProto   = 7'd9;
	localparam logic [6:0] IpCsumHi  = 7'd10;
	localparam logic [6:0] IpCsumLo  = 7'd11;

	typedef enum logic [1:0] {
		PROTO_ICMP  = 2'd0,
		PROTO_TCP   = 2'd1,
		PROTO_UDP   = 2'd2,
		PROTO_OTHER = 2'd3
	} proto_class_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       first;
	} frame_item_t;

	typedef struct packed {
		logic [MacW-1:0] dest_mac;
		logic [MacW-1:0] source_mac;
		logic [15:0]     ether_type;
		logic            is_ipv4;
		logic [15:0]     ip_total_length;
		logic [5:0]      ip_header_bytes;
		logic [7:0]      time_to_live;
		proto_class_t    protocol_class;
		logic [15:0]     stored_checksum;
		logic            checksum_ok;
	} header_item_t;

	function automatic proto_class_t classify_proto(input logic [7:0] proto);
		proto_class_t cls;
		case (proto)
			ProtoIcmp: cls = PROTO_ICMP;
			ProtoTcp:  cls = PROTO_TCP;
			ProtoUdp:  cls = PROTO_UDP;
			default:   cls = PROTO_OTHER;
		endcase
		return cls;
	endfunction

endpackage

@@ rtl/ehp_stream_if.sv @@
// ----------------------------------------------------------------------------
// ehp_stream_if
// valid / ready channel carrying one payload item per request
// ----------------------------------------------------------------------------
interface ehp_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ethernet_ipv4_header_parser.sv @@
// ----------------------------------------------------------------------------
// ethernet_ipv4_header_parser
// byte-wide ethernet and ipv4 header field capture with header checksum check
// ----------------------------------------------------------------------------
// a result request is loaded into the output register from the header-ending byte
// throughput: one frame byte per cycle unless a result stalls; single-byte parse step
// a stalled result holds only the byte that would produce the next result
// reset: asynchronous, clears both pipeline valid flags and waits for a first byte
module ethernet_ipv4_header_parser (
	input logic            clk,
	input logic            arst_n,
	ehp_stream_if.sink     frame,
	ehp_stream_if.source   header
);
	import ehp_pkg::*;

	// input register
	frame_item_t  item_s1;
	logic         valid_s1;

	// parse step outputs
	logic         emit;
	header_item_t result;
	logic         advance;

	// result register
	header_item_t result_q;
	logic         out_valid_q;
	logic         out_free;

	// the result slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || header.ready;

	// a byte that produces no result never waits on the output side
	assign advance = valid_s1 && (!emit || out_free);

	assign frame.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.ready && frame.valid) begin
			item_s1 <= frame.data;
		end
	end

	ehp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.emit   (emit),
		.result (result)
	);

	// output register: loads a new result or empties once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (header.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign header.valid = out_valid_q;
	assign header.data  = result_q;

endmodule

@@ rtl/ehp_parse.sv @@
// ----------------------------------------------------------------------------
// ehp_parse
// per-byte header state and result formation for one frame byte
// ----------------------------------------------------------------------------
module ehp_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  ehp_pkg::frame_item_t  item,
	output logic                  emit,
	output ehp_pkg::header_item_t result
);
	import ehp_pkg::*;

	logic [PosW-1:0] pos_q, pos_n;
	logic [MacW-1:0] dest_q, dest_n, dest_c;
	logic [MacW-1:0] src_q, src_n, src_c;
	logic [15:0]     type_q, type_n, type_c;
	logic [15:0]     len_q, len_n, len_c;
	logic [3:0]      ihl_q, ihl_n, ihl_c;
	logic [7:0]      ttl_q, ttl_n, ttl_c;
	logic [7:0]      proto_q, proto_n, proto_c;
	logic [15:0]     csum_q, csum_n, csum_c;
	logic [15:0]     sum_q, sum_n, sum_c;
	logic [7:0]      hi_q, hi_n, hi_c;
	logic            done_q, done_n, done_c;
	logic [PosW-1:0] pos_c, ip_pos;
	logic [5:0]      hdr_bytes, last_byte;
	logic [16:0]     sum_wide;
	logic [15:0]     sum_fold;
	logic            ip_emit, eth_emit;
	logic [7:0]      b;

	always_comb begin
		b = item.frame_byte;
		// a first byte restarts the frame from cleared holds
		if (item.first) begin
			pos_c = '0; dest_c = '0; src_c = '0; type_c = '0; len_c = '0;
			ihl_c = '0; ttl_c = '0; proto_c = '0; csum_c = '0; sum_c = '0;
			hi_c = '0; done_c = 1'b0;
		end else begin
			pos_c = pos_q; dest_c = dest_q; src_c = src_q; type_c = type_q;
			len_c = len_q; ihl_c = ihl_q; ttl_c = ttl_q; proto_c = proto_q;
			csum_c = csum_q; sum_c = sum_q; hi_c = hi_q; done_c = done_q;
		end

		dest_n = dest_c; src_n = src_c; type_n = type_c; len_n = len_c;
		ihl_n = ihl_c; ttl_n = ttl_c; proto_n = proto_c; csum_n = csum_c;
		sum_n = sum_c; hi_n = hi_c;

		ip_pos = pos_c - EthHdrBytes;

		if (!done_c) begin
			if (pos_c < SrcStart) begin
				dest_n = {dest_c[MacW-9:0], b};
			end else if (pos_c < TypeStart) begin
				src_n = {src_c[MacW-9:0], b};
			end else if (pos_c < EthHdrBytes) begin
				type_n = {type_c[7:0], b};
			end else begin
				case (ip_pos)
					IpVerIhl: ihl_n = b[3:0] & IhlMask[3:0];
					IpLenHi, IpLenLo: len_n = {len_c[7:0], b};
					IpTtl: ttl_n = b;
					IpProto: proto_n = b;
					IpCsumHi, IpCsumLo: csum_n = {csum_c[7:0], b};
					default: ;
				endcase
			end
		end

		hdr_bytes = {ihl_n, 2'b00};
		last_byte = (hdr_bytes > IpMinBytes) ? hdr_bytes - 6'd1 : IpMinBytes - 6'd1;

		// rfc 1071 end-around carry add of one big-endian word
		sum_wide = {1'b0, sum_c} + {1'b0, hi_c, b};
		sum_fold = sum_wide[15:0] + {15'd0, sum_wide[16]};

		eth_emit = !done_c && pos_c == EthTypeLast && type_n != EtherTypeIpv4;
		ip_emit  = !done_c && pos_c >= EthHdrBytes && ip_pos >= {1'b0, last_byte};

		if (!done_c && pos_c >= EthHdrBytes && ip_pos < {1'b0, hdr_bytes}) begin
			if (!ip_pos[0]) begin
				hi_n = b;
			end else begin
				sum_n = sum_fold;
			end
		end

		emit   = eth_emit || ip_emit;
		done_n = done_c || emit;
		pos_n  = (done_c || emit) ? pos_c : pos_c + 7'd1;
	end

	always_comb begin
		result.dest_mac        = dest_n;
		result.source_mac      = src_n;
		result.ether_type      = type_n;
		result.is_ipv4         = ip_emit;
		result.ip_total_length = ip_emit ? len_n : 16'd0;
		result.ip_header_bytes = ip_emit ? hdr_bytes : 6'd0;
		result.time_to_live    = ip_emit ? ttl_n : 8'd0;
		result.protocol_class  = ip_emit ? classify_proto(proto_n) : PROTO_ICMP;
		result.stored_checksum = ip_emit ? csum_n : 16'd0;
		result.checksum_ok     = ip_emit && sum_n == SumPass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; dest_q <= '0; src_q <= '0; type_q <= '0; len_q <= '0;
			ihl_q <= '0; ttl_q <= '0; proto_q <= '0; csum_q <= '0; sum_q <= '0;
			hi_q <= '0; done_q <= 1'b1;
		end else if (step) begin
			pos_q <= pos_n; dest_q <= dest_n; src_q <= src_n; type_q <= type_n;
			len_q <= len_n; ihl_q <= ihl_n; ttl_q <= ttl_n; proto_q <= proto_n;
			csum_q <= csum_n; sum_q <= sum_n; hi_q <= hi_n; done_q <= done_n;
		end
	end

endmodule
